// ===== rtl/osa_pkg.sv =====
// Shared constants, types and codes for the optimal string alignment distance block.
package osa_pkg;

    localparam int MAX_LEN = 16;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int COST_W  = $clog2(2 * MAX_LEN + 1);
    localparam int DIST_W  = 5;
    localparam int SYM_W   = 8;
    localparam int REQ_W   = 2;
    localparam int ROW_CNT = 3;
    localparam int DIST_MAX = (1 << DIST_W) - 1;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [COST_W-1:0] cost_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [SYM_W-1:0]  sym_t;
    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [1:0]        row_t;

    localparam req_t REQ_FIRST   = 2'd0;
    localparam req_t REQ_SECOND  = 2'd1;
    localparam req_t REQ_COMPUTE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        len_t  i;
        len_t  j;
        len_t  n;
        len_t  m;
        sym_t  a_i;
        sym_t  a_next;
        sym_t  b_j;
        sym_t  b_next;
        cost_t diag;
        cost_t left;
        cost_t up;
        cost_t back;
    } cell_operands_t;

endpackage

// ===== rtl/osa_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface osa_req_if import osa_pkg::*; ();
    logic valid;
    logic ready;
    req_t req_type;
    sym_t symbol;

    modport source (output valid, output req_type, output symbol, input ready);
    modport sink (input valid, input req_type, input symbol, output ready);
endinterface

interface osa_res_if import osa_pkg::*; ();
    logic  valid;
    logic  ready;
    dist_t distance;
    logic  overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink (input valid, input distance, input overflow, output ready);
endinterface

// ===== rtl/osa_edit_distance.sv =====
// Top level of the optimal string alignment distance block.
//
// Requests arrive on the request channel, one transfer per item. A request to
// append to the first or second string is taken while the block is idle; symbols
// past the string capacity are dropped and the overflow flag is set. A compute
// request walks the cost table one cell at a time, each cell in two steps
// (memory read, then cost and write-back); the next request is taken once the
// result is in the output register. The walk is set by the single cost unit and
// the read ports of the string and row memories. The request channel is not
// ready while a compute is in progress.
// The result is held in an output register. Loads continue to be taken while a
// result waits; a compute that finishes while the previous result is still held
// waits until the receiver takes it. A compute clears both strings and the flag.
// After reset both strings are empty, the flag is clear and no result is held.
module osa_edit_distance import osa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    osa_req_if.sink   request,
    osa_res_if.source result
);

    state_t state_reg;
    state_t state_next;

    len_t  first_len_reg;
    len_t  second_len_reg;
    logic  ovf_reg;
    len_t  i_reg;
    len_t  j_reg;
    row_t  r_reg;
    row_t  r1_reg;
    row_t  r2_reg;
    logic  out_valid_reg;
    dist_t out_dist_reg;
    logic  out_ovf_reg;

    cost_t left_reg;
    cost_t diag_reg;
    sym_t  a_i_reg;
    sym_t  a_next_reg;
    sym_t  b_j_reg;
    sym_t  b_next_reg;
    cost_t up_reg;
    cost_t back_reg;

    sym_t  first_mem  [MAX_LEN];
    sym_t  second_mem [MAX_LEN];
    cost_t cost_mem   [ROW_CNT][MAX_LEN+1];

    logic  in_xfer;
    logic  out_xfer;
    logic  start_compute;
    logic  load_first;
    logic  load_second;
    logic  cell_done;
    logic  row_done;
    logic  walk_done;
    logic  finish;

    logic [LEN_W:0] j_plus2;
    len_t           back_col;
    cell_operands_t ops;
    cost_t          cell_cost;

    assign in_xfer  = request.valid && request.ready;
    assign out_xfer = result.valid && result.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (request.req_type == REQ_COMPUTE))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = walk_done ? ST_FINISH : ST_READ;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        request.ready = 1'b0;
        cell_done     = 1'b0;
        finish        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                request.ready = 1'b1;
            end
            ST_READ:
            begin
            end
            ST_CALC:
            begin
                cell_done = 1'b1;
            end
            ST_FINISH:
            begin
                finish = !out_valid_reg || result.ready;
            end
            default:
            begin
            end
        endcase
        start_compute = in_xfer && (request.req_type == REQ_COMPUTE);
        load_first    = in_xfer && (request.req_type == REQ_FIRST);
        load_second   = in_xfer && (request.req_type == REQ_SECOND);
        row_done      = (j_reg == '0);
        walk_done     = row_done && (i_reg == '0);
    end

    always_comb
    begin
        j_plus2  = (LEN_W + 1)'(j_reg) + (LEN_W + 1)'(2);
        back_col = (j_plus2 <= (LEN_W + 1)'(second_len_reg)) ? len_t'(j_plus2) : j_reg;
        ops.i      = i_reg;
        ops.j      = j_reg;
        ops.n      = first_len_reg;
        ops.m      = second_len_reg;
        ops.a_i    = a_i_reg;
        ops.a_next = a_next_reg;
        ops.b_j    = b_j_reg;
        ops.b_next = b_next_reg;
        ops.diag   = diag_reg;
        ops.left   = left_reg;
        ops.up     = up_reg;
        ops.back   = back_reg;
    end

    osa_cost_unit u_cost
    (
        .ops  (ops),
        .cost (cell_cost)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            r_reg          <= 2'd0;
            r1_reg         <= 2'd1;
            r2_reg         <= 2'd2;
        end
        else
        begin
            state_reg <= state_next;
            if (load_first)
            begin
                if (first_len_reg < len_t'(MAX_LEN))
                begin
                    first_len_reg <= first_len_reg + len_t'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (load_second)
            begin
                if (second_len_reg < len_t'(MAX_LEN))
                begin
                    second_len_reg <= second_len_reg + len_t'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (start_compute)
            begin
                r_reg  <= 2'd0;
                r1_reg <= 2'd1;
                r2_reg <= 2'd2;
            end
            else if (cell_done && row_done && !walk_done)
            begin
                r_reg  <= r2_reg;
                r1_reg <= r_reg;
                r2_reg <= r1_reg;
            end
            if (finish)
            begin
                first_len_reg  <= '0;
                second_len_reg <= '0;
                ovf_reg        <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_compute)
        begin
            i_reg <= first_len_reg;
            j_reg <= second_len_reg;
        end
        else if (cell_done)
        begin
            left_reg <= cell_cost;
            diag_reg <= up_reg;
            if (row_done)
            begin
                if (!walk_done)
                begin
                    i_reg <= i_reg - len_t'(1);
                    j_reg <= second_len_reg;
                end
            end
            else
            begin
                j_reg <= j_reg - len_t'(1);
            end
        end
        if (finish)
        begin
            out_dist_reg <= (left_reg > cost_t'(DIST_MAX)) ? dist_t'(DIST_MAX)
                                                          : dist_t'(left_reg);
            out_ovf_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_first && (first_len_reg < len_t'(MAX_LEN)))
        begin
            first_mem[idx_t'(first_len_reg)] <= request.symbol;
        end
        if (load_second && (second_len_reg < len_t'(MAX_LEN)))
        begin
            second_mem[idx_t'(second_len_reg)] <= request.symbol;
        end
        if (state_reg == ST_READ)
        begin
            a_i_reg    <= first_mem[idx_t'(i_reg)];
            a_next_reg <= first_mem[idx_t'(i_reg + len_t'(1))];
            b_j_reg    <= second_mem[idx_t'(j_reg)];
            b_next_reg <= second_mem[idx_t'(j_reg + len_t'(1))];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_done)
        begin
            cost_mem[r_reg][j_reg] <= cell_cost;
        end
        if (state_reg == ST_READ)
        begin
            up_reg   <= cost_mem[r1_reg][j_reg];
            back_reg <= cost_mem[r2_reg][back_col];
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.distance = out_dist_reg;
    assign result.overflow = out_ovf_reg;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= len_t'(MAX_LEN)) && (second_len_reg <= len_t'(MAX_LEN)))
        else $error("String length beyond capacity.");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (i_reg <= first_len_reg) && (j_reg <= second_len_reg))
        else $error("Cell index outside the table.");

    a_rows_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (r_reg != r1_reg) && (r1_reg != r2_reg)
            && (r_reg != r2_reg) && (r_reg != 2'd3) && (r1_reg != 2'd3) && (r2_reg != 2'd3))
        else $error("Cost rows overlap.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("Result appeared without a finished compute.");

    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (first_len_reg == '0) && (second_len_reg == '0) && !ovf_reg
            && (state_reg == ST_IDLE))
        else $error("Strings not cleared after compute.");
`endif

endmodule

// ===== rtl/osa_cost_unit.sv =====
// Cost of one table cell from its neighbours, shared by every cell of the walk.
module osa_cost_unit import osa_pkg::*;
(
    input  cell_operands_t ops,
    output cost_t          cost
);

    logic          boundary;
    logic          swap_ok;
    logic [LEN_W:0] i_plus2;
    logic [LEN_W:0] j_plus2;
    cost_t         edge_cost;
    cost_t         subst_cost;
    cost_t         ins_cost;
    cost_t         del_cost;
    cost_t         swap_cost;
    cost_t         best_a;
    cost_t         best_b;

    always_comb
    begin
        boundary   = (ops.i == ops.n) || (ops.j == ops.m);
        edge_cost  = cost_t'(ops.n - ops.i) + cost_t'(ops.m - ops.j);
        i_plus2    = (LEN_W + 1)'(ops.i) + (LEN_W + 1)'(2);
        j_plus2    = (LEN_W + 1)'(ops.j) + (LEN_W + 1)'(2);
        swap_ok    = (i_plus2 <= (LEN_W + 1)'(ops.n)) && (j_plus2 <= (LEN_W + 1)'(ops.m))
                     && (ops.a_i == ops.b_next) && (ops.a_next == ops.b_j);
        subst_cost = ops.diag + cost_t'(ops.a_i != ops.b_j);
        ins_cost   = ops.left + cost_t'(1);
        del_cost   = ops.up + cost_t'(1);
        swap_cost  = ops.back + cost_t'(1);
        best_a     = (ins_cost < subst_cost) ? ins_cost : subst_cost;
        best_b     = (del_cost < best_a) ? del_cost : best_a;
        if (swap_ok && (swap_cost < best_b))
        begin
            best_b = swap_cost;
        end
        cost = boundary ? edge_cost : best_b;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the optimal string alignment distance block.
module testbench import osa_pkg::*;
();

    localparam req_t REQ_UNUSED = 2'd3;
    localparam int   RANDOM_ITEMS = 1600;

    typedef struct {
        req_t  req_type;
        sym_t  symbol;
        int    phase;
        bit    hold;
    } load_item_t;

    typedef struct {
        dist_t distance;
        logic  overflow;
    } osa_result_t;

    logic clk = 1'b0;
    logic rst_n;

    osa_req_if req_if ();
    osa_res_if res_if ();

    osa_edit_distance DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if)
    );

    always #5 clk = ~clk;

    load_item_t  request_queue[$];
    osa_result_t results_due[$];
    int          errors = 0;
    int unsigned rx_stall = 0;
    int unsigned send_gap_pct[3] = '{16, 70, 0};
    int unsigned recv_stall_pct[3] = '{70, 16, 0};

    sym_t first_syms[MAX_LEN];
    sym_t second_syms[MAX_LEN];
    int   first_len = 0;
    int   second_len = 0;
    logic dropped_seen = 1'b0;

    function automatic dist_t loaded_distance();
        int cost[MAX_LEN+1][MAX_LEN+1];
        int c;
        for (int i = first_len; i >= 0; i--)
        begin
            for (int j = second_len; j >= 0; j--)
            begin
                if (i == first_len || j == second_len)
                begin
                    c = (first_len - i) + (second_len - j);
                end
                else
                begin
                    c = cost[i+1][j+1] + ((first_syms[i] != second_syms[j]) ? 1 : 0);
                    if (cost[i][j+1] + 1 < c)
                        c = cost[i][j+1] + 1;
                    if (cost[i+1][j] + 1 < c)
                        c = cost[i+1][j] + 1;
                    if (i + 2 <= first_len && j + 2 <= second_len &&
                        first_syms[i] == second_syms[j+1] &&
                        first_syms[i+1] == second_syms[j] &&
                        cost[i+2][j+2] + 1 < c)
                        c = cost[i+2][j+2] + 1;
                end
                cost[i][j] = c;
            end
        end
        return (cost[0][0] > DIST_MAX) ? dist_t'(DIST_MAX) : dist_t'(cost[0][0]);
    endfunction

    function automatic void apply_request(req_t kind, sym_t sym);
        osa_result_t res;
        case (kind)
            REQ_FIRST:
                if (first_len < MAX_LEN)
                begin
                    first_syms[first_len] = sym;
                    first_len++;
                end
                else
                begin
                    dropped_seen = 1'b1;
                end
            REQ_SECOND:
                if (second_len < MAX_LEN)
                begin
                    second_syms[second_len] = sym;
                    second_len++;
                end
                else
                begin
                    dropped_seen = 1'b1;
                end
            REQ_COMPUTE:
            begin
                res.distance = loaded_distance();
                res.overflow = dropped_seen;
                results_due.push_back(res);
                first_len = 0;
                second_len = 0;
                dropped_seen = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void push_request(req_t kind, sym_t sym, int phase, bit hold);
        load_item_t item;
        item.req_type = kind;
        item.symbol = sym;
        item.phase = phase;
        item.hold = hold;
        request_queue.push_back(item);
    endfunction

    function automatic int queue_string_pair(int phase, bit hold);
        sym_t a[$];
        sym_t b[$];
        sym_t t;
        int   len_a;
        int   len_b;
        int   pick;
        int   pos;
        int   ia;
        int   ib;
        int   count;
        bit   narrow;
        sym_t base;
        count = 0;
        narrow = 1'($urandom_range(0, 1));
        base = sym_t'($urandom_range(0, 252));
        pick = $urandom_range(0, 99);
        len_a = (pick < 8) ? 0 : (pick < 80) ? $urandom_range(1, 8) :
                (pick < 92) ? $urandom_range(9, 16) : $urandom_range(17, 19);
        for (int k = 0; k < len_a; k++)
            a.push_back(narrow ? sym_t'(base + $urandom_range(0, 3)) : sym_t'($urandom));
        if ($urandom_range(0, 99) < 60)
        begin
            b = a;
            repeat ($urandom_range(0, 3))
            begin
                pos = (b.size() == 0) ? 0 : $urandom_range(0, b.size() - 1);
                case ($urandom_range(0, 3))
                    0:
                        if (b.size() != 0)
                            b[pos] = narrow ? sym_t'(base + $urandom_range(0, 3))
                                            : sym_t'($urandom);
                    1:
                        if (pos + 1 < b.size())
                        begin
                            t = b[pos];
                            b[pos] = b[pos+1];
                            b[pos+1] = t;
                        end
                    2:
                        b.insert(pos, sym_t'($urandom));
                    default:
                        if (b.size() != 0)
                            b.delete(pos);
                endcase
            end
        end
        else
        begin
            pick = $urandom_range(0, 99);
            len_b = (pick < 8) ? 0 : (pick < 80) ? $urandom_range(1, 8) :
                    (pick < 92) ? $urandom_range(9, 16) : $urandom_range(17, 19);
            for (int k = 0; k < len_b; k++)
                b.push_back(narrow ? sym_t'(base + $urandom_range(0, 3)) : sym_t'($urandom));
        end
        ia = 0;
        ib = 0;
        while (ia < a.size() || ib < b.size())
        begin
            if ($urandom_range(0, 32) == 0)
                push_request(REQ_UNUSED, sym_t'($urandom), phase, 1'b0);
            if (ib >= b.size() || (ia < a.size() && $urandom_range(0, 1) == 1))
            begin
                push_request(REQ_FIRST, a[ia], phase, hold);
                ia++;
            end
            else
            begin
                push_request(REQ_SECOND, b[ib], phase, hold);
                ib++;
            end
            hold = 1'b0;
            count++;
        end
        push_request(REQ_COMPUTE, sym_t'($urandom), phase, hold);
        count++;
        if ($urandom_range(0, 19) == 0)
        begin
            push_request(REQ_COMPUTE, sym_t'($urandom), phase, 1'b0);
            count++;
        end
        return count;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        load_item_t head;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.req_type <= REQ_FIRST;
            req_if.symbol <= '0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                apply_request(req_if.req_type, req_if.symbol);
            if (!req_if.valid || req_if.ready)
            begin
                if (request_queue.size() != 0 &&
                    !(request_queue[0].hold && results_due.size() != 0) &&
                    $urandom_range(0, 99) >= send_gap_pct[request_queue[0].phase])
                begin
                    head = request_queue.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.req_type <= head.req_type;
                    req_if.symbol <= head.symbol;
                    rx_stall <= recv_stall_pct[head.phase];
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        osa_result_t want;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: distance %0d overflow %0b",
                           res_if.distance, res_if.overflow);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (res_if.distance !== want.distance)
                    begin
                        $error("distance: expected %0d, actual %0d",
                               want.distance, res_if.distance);
                        errors++;
                    end
                    if (res_if.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, res_if.overflow);
                        errors++;
                    end
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= rx_stall);
        end
    end

    initial
    begin
        int real_items;
        int phase;
        int last_phase;
        rst_n = 1'b0;

        push_request(REQ_COMPUTE, 8'h00, 0, 1'b0);
        push_request(REQ_FIRST, 8'h00, 0, 1'b0);
        push_request(REQ_FIRST, 8'hFF, 0, 1'b0);
        push_request(REQ_SECOND, 8'hFF, 0, 1'b0);
        push_request(REQ_SECOND, 8'h00, 0, 1'b0);
        push_request(REQ_COMPUTE, 8'hFF, 0, 1'b0);
        push_request(REQ_UNUSED, 8'hA5, 0, 1'b0);
        push_request(REQ_UNUSED, 8'h5A, 0, 1'b0);
        push_request(REQ_FIRST, 8'hFF, 0, 1'b0);
        push_request(REQ_COMPUTE, 8'h00, 0, 1'b0);
        push_request(REQ_SECOND, 8'h41, 0, 1'b0);
        push_request(REQ_SECOND, 8'h42, 0, 1'b0);
        push_request(REQ_COMPUTE, 8'h00, 0, 1'b0);
        push_request(REQ_FIRST, 8'h61, 0, 1'b0);
        push_request(REQ_SECOND, 8'h61, 0, 1'b0);
        push_request(REQ_COMPUTE, 8'h00, 0, 1'b0);
        push_request(REQ_FIRST, 8'h61, 0, 1'b0);
        push_request(REQ_SECOND, 8'h62, 0, 1'b0);
        push_request(REQ_COMPUTE, 8'h00, 0, 1'b0);

        real_items = 0;
        last_phase = 0;
        while (real_items < RANDOM_ITEMS)
        begin
            phase = real_items * 3 / RANDOM_ITEMS;
            real_items += queue_string_pair(phase,
                                            phase != last_phase || $urandom_range(0, 49) == 0);
            last_phase = phase;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_queue.size() != 0 || req_if.valid || results_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
